@@ src/mss_pkg.sv @@
// Package for the melody string sequencer: payload types, action codes,
// command/status structs, tone table and constants. No dependencies.
`timescale 1ns / 1ps
package mss_pkg;

    localparam int SongDepthDefault = 64;
    localparam int ToneCount = 36;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_MS   = 2'd1;
    localparam logic [1:0] ACT_US   = 2'd2;
    localparam logic [1:0] ACT_STOP = 2'd3;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] song_char;
        logic       first_char;
    } mss_in_t;

    typedef struct packed {
        logic        pin_level;
        logic        tone_on;
        logic        playing;
        logic [15:0] tone_period_us;
    } mss_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;     // register the input item
        logic do_load;     // store char / first_char handling
        logic do_us;       // microsecond tick
        logic do_stop;     // stop all sound
        logic ms_begin;    // millisecond tick countdown step
        logic scan_start;  // reset scan accumulators
        logic scan_read;   // issue read at read_index
        logic scan_eval;   // evaluate returned character
        logic fin_a;       // compute note time
        logic fin_b;       // apply swing
        logic fin_c;       // apply staccato and commit note
        logic end_song;    // end of store reached
        logic out_load;    // load output register
    } mss_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] action;
        logic       need_scan;  // ms tick asks for next note
        logic       scan_more;  // read_index below length
        logic       found;      // note or rest found
    } mss_sts_t;

    function automatic logic [15:0] tone_lookup(input logic [5:0] idx);
        logic [15:0] v;
        begin
            unique case (idx)
                6'd0:  v = 16'd7645; 6'd1:  v = 16'd7167; 6'd2:  v = 16'd6796;
                6'd3:  v = 16'd6371; 6'd4:  v = 16'd6116; 6'd5:  v = 16'd5734;
                6'd6:  v = 16'd5437; 6'd7:  v = 16'd5297; 6'd8:  v = 16'd4778;
                6'd9:  v = 16'd4587; 6'd10: v = 16'd4247; 6'd11: v = 16'd4177;
                6'd12: v = 16'd3823; 6'd13: v = 16'd3584; 6'd14: v = 16'd3398;
                6'd15: v = 16'd3186; 6'd16: v = 16'd3058; 6'd17: v = 16'd2867;
                6'd18: v = 16'd2718; 6'd19: v = 16'd2548; 6'd20: v = 16'd2389;
                6'd21: v = 16'd2294; 6'd22: v = 16'd2124; 6'd23: v = 16'd2039;
                6'd24: v = 16'd1911; 6'd25: v = 16'd1792; 6'd26: v = 16'd1699;
                6'd27: v = 16'd1592; 6'd28: v = 16'd1529; 6'd29: v = 16'd1433;
                6'd30: v = 16'd1359; 6'd31: v = 16'd1274; 6'd32: v = 16'd1194;
                6'd33: v = 16'd1147; 6'd34: v = 16'd1062; 6'd35: v = 16'd1019;
                default: v = 16'd0;
            endcase
            return v;
        end
    endfunction

endpackage

@@ src/mss_ram.sv @@
// Generic RAM with a write port and a registered read port for the
// song store. No dependencies.
`timescale 1ns / 1ps
module mss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

@@ src/mss_ctrl.sv @@
// Controller state machine for the melody sequencer.
// Depends on mss_pkg.
`timescale 1ns / 1ps
module mss_ctrl import mss_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  logic     out_free,
    input  mss_sts_t sts,
    output mss_cmd_t cmd
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EXEC  = 4'd1;
    localparam logic [3:0] S_MS    = 4'd2;
    localparam logic [3:0] S_SCAN  = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_FINA  = 4'd6;
    localparam logic [3:0] S_FINB  = 4'd7;
    localparam logic [3:0] S_FINC  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (sts.action)
                    ACT_LOAD: begin cmd.do_load = 1'b1; state_next = S_OUT; end
                    ACT_US:   begin cmd.do_us = 1'b1; state_next = S_OUT; end
                    ACT_STOP: begin cmd.do_stop = 1'b1; state_next = S_OUT; end
                    default:  begin cmd.ms_begin = 1'b1; state_next = S_MS; end
                endcase
            end
            S_MS:
            begin
                if (sts.need_scan)
                begin
                    cmd.scan_start = 1'b1;
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                if (sts.found)
                begin
                    state_next = S_FINA;
                end
                else if (sts.scan_more)
                begin
                    cmd.scan_read = 1'b1;
                    state_next = S_WAIT;
                end
                else
                begin
                    cmd.end_song = 1'b1;
                    state_next = S_OUT;
                end
            end
            // read data is valid for exactly this cycle
            S_WAIT:
            begin
                cmd.scan_eval = 1'b1;
                state_next = S_SCAN;
            end
            S_FINA: begin cmd.fin_a = 1'b1; state_next = S_FINB; end
            S_FINB: begin cmd.fin_b = 1'b1; state_next = S_FINC; end
            S_FINC: begin cmd.fin_c = 1'b1; state_next = S_OUT; end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> state_reg == S_IDLE)
        else $error("output load did not return to idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_read |=> state_reg == S_WAIT)
        else $error("read not followed by wait");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.capture |-> state_reg == S_IDLE)
        else $error("capture outside idle");
endmodule

@@ src/mss_dp.sv @@
// Datapath of the melody sequencer: song store, timing and tone registers.
// Depends on mss_pkg and mss_ram.
`timescale 1ns / 1ps
module mss_dp import mss_pkg::*; #(
    parameter int SONG_DEPTH = SongDepthDefault
) (
    input  logic     clk,
    input  logic     rst_n,
    input  mss_in_t  in_item,
    input  mss_cmd_t cmd,
    output mss_sts_t sts,
    output mss_out_t result
);
    localparam int AW = $clog2(SONG_DEPTH);
    localparam int LW = $clog2(SONG_DEPTH + 1);

    mss_in_t     item_reg;
    logic [LW-1:0] len_reg, rix_reg;
    logic [15:0] rem_reg, gap_reg;
    logic [10:0] base_reg;
    logic        stac_reg, swa_reg, swl_reg, oct_reg;
    logic [15:0] half_reg, usc_reg, period_reg;
    logic        pin_reg;
    logic        need_reg;
    // scan accumulators
    logic signed [7:0] note_reg;
    logic        found_reg, dot_reg;
    // finish pipeline
    logic [11:0] t_reg;
    logic [11:0] tf_reg;
    logic [15:0] np_reg;

    logic [7:0]  rdata;
    logic        we;

    assign we = cmd.do_load && item_reg.song_char != 8'd0
                && ((item_reg.first_char ? LW'(0) : len_reg) < LW'(SONG_DEPTH));

    mss_ram #(.WIDTH(8), .DEPTH(SONG_DEPTH)) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (item_reg.first_char ? AW'(0) : len_reg[AW-1:0]),
        .wdata (item_reg.song_char),
        .raddr (rix_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign sts.action    = item_reg.action;
    assign sts.need_scan = need_reg;
    assign sts.scan_more = rix_reg < len_reg;
    assign sts.found     = found_reg;

    // note time arithmetic
    logic [11:0] by3;
    logic [6:0]  idx;
    logic [15:0] per;
    logic [14:0] x4;
    logic [23:0] div5_prod;
    always_comb
    begin
        by3 = 12'((24'(t_reg) * 24'd2731) >> 13);
        if (12'(by3 * 12'd3) > t_reg)
        begin
            by3 = by3 - 12'd1;
        end
    end
    assign x4 = 15'(tf_reg) << 2;
    assign div5_prod = 24'((30'(x4) * 30'd52429) >> 18);
    assign idx = 7'(note_reg + (oct_reg ? 8'sd12 : 8'sd0));
    assign per = ($signed(idx) >= 0 && idx < 7'd36) ? tone_lookup(idx[5:0]) : 16'd0;

    logic [12:0] tsw;
    always_comb
    begin
        if (!swa_reg)
            tsw = 13'(t_reg);
        else if (swl_reg)
            tsw = 13'(t_reg) + 13'(by3);
        else
            tsw = 13'(t_reg) - 13'(by3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_reg <= '0;
            len_reg <= '0; rix_reg <= '0; rem_reg <= '0; gap_reg <= '0;
            base_reg <= 11'd200; stac_reg <= 1'b1; swa_reg <= 1'b0;
            swl_reg <= 1'b0; oct_reg <= 1'b0;
            half_reg <= '0; usc_reg <= '0; period_reg <= '0; pin_reg <= 1'b0;
            need_reg <= 1'b0; note_reg <= '0; found_reg <= 1'b0; dot_reg <= 1'b0;
            t_reg <= '0; tf_reg <= '0; np_reg <= '0;
        end
        else
        begin
            if (cmd.capture) item_reg <= in_item;
            if (cmd.do_load)
            begin
                if (item_reg.first_char)
                begin
                    rix_reg <= '0; base_reg <= 11'd200; stac_reg <= 1'b1;
                    swa_reg <= 1'b0;
                    len_reg <= we ? LW'(1) : LW'(0);
                end
                else if (we)
                begin
                    len_reg <= len_reg + LW'(1);
                end
            end
            if (cmd.do_us && period_reg != 16'd0)
            begin
                if (usc_reg >= half_reg)
                begin
                    usc_reg <= '0; pin_reg <= ~pin_reg;
                end
                else
                begin
                    usc_reg <= usc_reg + 16'd1;
                end
            end
            if (cmd.do_stop || cmd.end_song)
            begin
                len_reg <= '0; rix_reg <= '0;
                period_reg <= '0; half_reg <= '0; usc_reg <= '0; pin_reg <= 1'b0;
                rem_reg <= '0; gap_reg <= '0;
            end
            if (cmd.ms_begin)
            begin
                if (rem_reg == 16'd1 && gap_reg != 16'd0)
                begin
                    // sounding part over: go quiet for the gap
                    period_reg <= '0; half_reg <= '0; usc_reg <= '0;
                    pin_reg <= 1'b0;
                    rem_reg <= gap_reg; gap_reg <= '0;
                    need_reg <= 1'b0;
                end
                else if (rem_reg != 16'd0)
                begin
                    rem_reg <= rem_reg - 16'd1;
                    need_reg <= (rem_reg == 16'd1);
                end
                else
                begin
                    need_reg <= (rix_reg == '0) && (len_reg != '0);
                end
            end
            if (cmd.scan_start)
            begin
                note_reg <= '0; found_reg <= 1'b0; dot_reg <= 1'b0;
            end
            if (cmd.scan_read) rix_reg <= rix_reg + LW'(1);
            if (cmd.scan_eval)
            begin
                unique case (rdata)
                    "1": begin base_reg <= 11'd1600; swa_reg <= 1'b0; end
                    "2": begin base_reg <= 11'd800;  swa_reg <= 1'b0; end
                    "4": begin base_reg <= 11'd400;  swa_reg <= 1'b0; end
                    "8": begin base_reg <= 11'd200;  swa_reg <= 1'b0; end
                    "6": begin base_reg <= 11'd100;  swa_reg <= 1'b0; end
                    "3": begin base_reg <= 11'd50;   swa_reg <= 1'b0; end
                    ".": dot_reg <= 1'b1;
                    "T": oct_reg <= 1'b1;
                    "t": oct_reg <= 1'b0;
                    "+": note_reg <= note_reg + 8'sd1;
                    "-": note_reg <= note_reg - 8'sd1;
                    "c": found_reg <= 1'b1;
                    "d": begin note_reg <= note_reg + 8'sd2;  found_reg <= 1'b1; end
                    "e": begin note_reg <= note_reg + 8'sd4;  found_reg <= 1'b1; end
                    "f": begin note_reg <= note_reg + 8'sd5;  found_reg <= 1'b1; end
                    "g": begin note_reg <= note_reg + 8'sd7;  found_reg <= 1'b1; end
                    "a": begin note_reg <= note_reg + 8'sd9;  found_reg <= 1'b1; end
                    "b": begin note_reg <= note_reg + 8'sd11; found_reg <= 1'b1; end
                    "C": begin note_reg <= note_reg + 8'sd12; found_reg <= 1'b1; end
                    "D": begin note_reg <= note_reg + 8'sd14; found_reg <= 1'b1; end
                    "E": begin note_reg <= note_reg + 8'sd16; found_reg <= 1'b1; end
                    "F": begin note_reg <= note_reg + 8'sd17; found_reg <= 1'b1; end
                    "G": begin note_reg <= note_reg + 8'sd19; found_reg <= 1'b1; end
                    "A": begin note_reg <= note_reg + 8'sd21; found_reg <= 1'b1; end
                    "B": begin note_reg <= note_reg + 8'sd23; found_reg <= 1'b1; end
                    " ": begin note_reg <= 8'sd36; found_reg <= 1'b1; end
                    "_": stac_reg <= 1'b0;
                    "^": stac_reg <= 1'b1;
                    "~": begin swa_reg <= 1'b1; swl_reg <= 1'b1; end
                    default: ;
                endcase
            end
            if (cmd.fin_a)
            begin
                t_reg <= 12'(base_reg) + (dot_reg ? 12'(base_reg >> 1) : 12'd0);
                np_reg <= per;
            end
            if (cmd.fin_b)
            begin
                tf_reg <= 12'(tsw);
                if (swa_reg) swl_reg <= ~swl_reg;
            end
            if (cmd.fin_c)
            begin
                rem_reg <= 16'(stac_reg ? 12'(div5_prod) : tf_reg);
                gap_reg <= 16'(tf_reg - (stac_reg ? 12'(div5_prod) : tf_reg));
                if (np_reg == 16'd0)
                begin
                    period_reg <= '0; half_reg <= '0; usc_reg <= '0; pin_reg <= 1'b0;
                end
                else
                begin
                    period_reg <= np_reg; half_reg <= np_reg >> 1; usc_reg <= '0;
                end
            end
        end
    end

    assign result.pin_level      = pin_reg;
    assign result.tone_on        = period_reg != 16'd0;
    assign result.playing        = (period_reg != 16'd0) || (rix_reg < len_reg);
    assign result.tone_period_us = period_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (period_reg == 16'd0) |-> (pin_reg == 1'b0 || cmd.fin_c == 1'b0 || 1'b1))
        else $error("unreachable");
    assert property (@(posedge clk) disable iff (!rst_n)
        half_reg == (period_reg >> 1))
        else $error("half period out of step with period");
    assert property (@(posedge clk) disable iff (!rst_n)
        rix_reg <= len_reg || len_reg == '0)
        else $error("read index past song length");
    assert property (@(posedge clk) disable iff (!rst_n)
        (period_reg == 16'd0) |-> usc_reg == 16'd0)
        else $error("counter running while silent");
endmodule

@@ src/melody_string_sequencer_core.sv @@
// Top level of the melody string sequencer: controller, datapath and
// output register. Depends on mss_pkg, mss_ctrl, mss_dp.
//
// Usage: each input transfer carries an action (load a song character,
// millisecond tick, microsecond tick, stop). Every accepted item gives
// exactly one result transfer with the pin level, tone state, playing
// flag and tone period after that action.
// Load, microsecond tick and stop go from the execute state to the
// output state; a millisecond tick without a new note also passes the
// tick state. A tick that fetches a note reads and evaluates the song
// store character by character through the single RAM read port, then
// passes FINA, FINB and FINC. One item is in flight at a time.
// The result waits in an output register; the next item is taken as
// soon as the result has been loaded there, even if the receiver stalls.
// Reset clears all control state; the song store content is undefined
// and only entries below the song length are read.
`timescale 1ns / 1ps
module melody_string_sequencer_core import mss_pkg::*; #(
    parameter int SONG_DEPTH = SongDepthDefault
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  mss_in_t  in_data,
    output logic     out_valid,
    input  logic     out_stall,
    output mss_out_t out_data
);
    mss_cmd_t cmd;
    mss_sts_t sts;
    mss_out_t result;
    logic     out_valid_reg;
    mss_out_t out_data_reg;
    logic     out_free;

    // output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || !out_stall;

    mss_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .out_free (out_free),
        .sts      (sts),
        .cmd      (cmd)
    );

    mss_dp #(.SONG_DEPTH(SONG_DEPTH)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_item (in_data),
        .cmd     (cmd),
        .sts     (sts),
        .result  (result)
    );

    // hold result until transferred
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(out_data))
        else $error("stalled result changed");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output overwritten");
endmodule

@@ tb/melody_string_sequencer_core_tb.sv @@
// Self-checking testbench for melody_string_sequencer_core: drives song loads and
// timer ticks, predicts every result with a behavioural buzzer model and compares.
// Depends on mss_pkg and the core RTL.
`timescale 1ns / 1ps
module melody_string_sequencer_core_tb;
    import mss_pkg::*;

    localparam int Depth = 64;
    localparam int WatchdogLimit = 20000;
    localparam int HoldCycles = 300;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    mss_in_t in_data;
    logic out_valid;
    logic out_stall;
    mss_out_t out_data;

    melody_string_sequencer_core #(.SONG_DEPTH(Depth)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
    );

    // Buzzer model state
    logic [7:0] song_mem [Depth];
    int unsigned song_len, play_pos, note_left_ms, gap_left_ms, beat_ms;
    bit legato_off, swing_on, swing_long, transpose;
    int unsigned half_per, us_count, period_us;
    bit pin;

    mss_out_t pending_results[$];
    int mismatches;
    int idle_cycles;
    bit timed_out;
    bit hold_receiver;
    bit rx_random;

    const int unsigned tones[36] = '{
        7645, 7167, 6796, 6371, 6116, 5734, 5437, 5297, 4778, 4587, 4247, 4177,
        3823, 3584, 3398, 3186, 3058, 2867, 2718, 2548, 2389, 2294, 2124, 2039,
        1911, 1792, 1699, 1592, 1529, 1433, 1359, 1274, 1194, 1147, 1062, 1019};

    function automatic void silence();
        period_us = 0; half_per = 0; us_count = 0; pin = 0;
    endfunction

    function automatic void fetch_note();
        int note;
        int idx;
        bit found;
        bit dotted;
        int unsigned t, dur, by, per;
        logic [7:0] c;
        note = 0; found = 0; dotted = 0;
        while (play_pos < song_len && !found) begin
            c = song_mem[play_pos];
            play_pos++;
            case (c)
                "1": begin beat_ms = 1600; swing_on = 0; end
                "2": begin beat_ms = 800; swing_on = 0; end
                "4": begin beat_ms = 400; swing_on = 0; end
                "8": begin beat_ms = 200; swing_on = 0; end
                "6": begin beat_ms = 100; swing_on = 0; end
                "3": begin beat_ms = 50; swing_on = 0; end
                ".": dotted = 1;
                "T": transpose = 1;
                "t": transpose = 0;
                "+": note++;
                "-": note--;
                "c": found = 1;
                "d": begin note += 2; found = 1; end
                "e": begin note += 4; found = 1; end
                "f": begin note += 5; found = 1; end
                "g": begin note += 7; found = 1; end
                "a": begin note += 9; found = 1; end
                "b": begin note += 11; found = 1; end
                "C": begin note += 12; found = 1; end
                "D": begin note += 14; found = 1; end
                "E": begin note += 16; found = 1; end
                "F": begin note += 17; found = 1; end
                "G": begin note += 19; found = 1; end
                "A": begin note += 21; found = 1; end
                "B": begin note += 23; found = 1; end
                " ": begin note = 36; found = 1; end
                "_": legato_off = 0;
                "^": legato_off = 1;
                "~": begin swing_on = 1; swing_long = 1; end
                default: ;
            endcase
        end
        if (!found) begin
            // ran off the end of the song: go quiet and forget it
            silence();
            song_len = 0; play_pos = 0; note_left_ms = 0; gap_left_ms = 0;
            return;
        end
        idx = note + (transpose ? 12 : 0);
        per = (idx >= 0 && idx < 36) ? tones[idx] : 0;
        t = beat_ms + (dotted ? beat_ms >> 1 : 0);
        if (swing_on) begin
            by = t / 3;
            t = swing_long ? t + by : t - by;
            swing_long = !swing_long;
        end
        dur = legato_off ? (t * 4) / 5 : t;
        if (per == 0) silence();
        else begin
            period_us = per; half_per = per >> 1; us_count = 0;
        end
        note_left_ms = dur & 16'hFFFF;
        gap_left_ms = (t - dur) & 16'hFFFF;
    endfunction

    function automatic mss_out_t buzzer_step(mss_in_t it);
        mss_out_t r;
        case (it.action)
            ACT_LOAD: begin
                if (it.first_char) begin
                    song_len = 0; play_pos = 0; beat_ms = 200; legato_off = 1; swing_on = 0;
                end
                if (it.song_char != 0 && song_len < Depth) begin
                    song_mem[song_len] = it.song_char;
                    song_len++;
                end
            end
            ACT_MS: begin
                if (note_left_ms > 0) begin
                    note_left_ms--;
                    if (note_left_ms == 0) begin
                        if (gap_left_ms != 0) begin
                            silence();
                            note_left_ms = gap_left_ms;
                            gap_left_ms = 0;
                        end else fetch_note();
                    end
                end else if (play_pos == 0 && song_len > 0) fetch_note();
            end
            ACT_US: begin
                if (period_us != 0) begin
                    if (us_count >= half_per) begin
                        us_count = 0; pin = !pin;
                    end else us_count++;
                end
            end
            default: begin
                song_len = 0; play_pos = 0; silence(); note_left_ms = 0; gap_left_ms = 0;
            end
        endcase
        r.pin_level = pin;
        r.tone_on = period_us != 0;
        r.playing = period_us != 0 || play_pos < song_len;
        r.tone_period_us = period_us[15:0];
        return r;
    endfunction

    initial
    begin
        clk = 0;
        forever #4 clk = !clk;
    end

    // Valid drops after each transfer before the next item.
    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 1;
        if (p < 92) return $urandom_range(2, 4);
        return $urandom_range(8, 40);
    endfunction

    // Send one item; hold the payload until the transfer happens.
    task automatic send_item(logic [1:0] act, logic [7:0] ch, logic first);
        int g;
        mss_in_t it;
        g = gap_length();
        repeat (g) @(posedge clk);
        it.action = act; it.song_char = ch; it.first_char = first;
        in_valid <= 1'b1;
        in_data <= it;
        pending_results.push_back(buzzer_step(it));
        do @(posedge clk); while (in_stall);
        in_valid <= 1'b0;
    endtask

    task automatic load_song(string s);
        for (int i = 0; i < s.len(); i++)
            send_item(ACT_LOAD, s[i], i == 0);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // Random US ticks sometimes, otherwise ms ticks, to advance the song
    task automatic play_ticks(int n);
        for (int i = 0; i < n; i++)
            send_item($urandom_range(0, 2) == 0 ? ACT_US : ACT_MS, 8'($urandom),
                1'($urandom));
    endtask

    function automatic logic [7:0] song_symbol();
        string alphabet;
        alphabet = "124863.Tt+-cdefgabCDEFGAB _^~";
        if ($urandom_range(0, 19) == 0) return 8'($urandom);
        return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endfunction

    task automatic test_directed();
        // edge characters, several notation symbols, transpose off the top of the table
        load_song("3.T+B-c");
        play_ticks(20);
        send_item(ACT_LOAD, 8'h00, 1'b1);
        send_item(ACT_LOAD, 8'hFF, 1'b0);
        send_item(ACT_LOAD, "~", 1'b0);
        send_item(ACT_LOAD, "_", 1'b0);
        send_item(ACT_LOAD, "3", 1'b0);
        send_item(ACT_LOAD, "a", 1'b0);
        send_item(ACT_LOAD, " ", 1'b0);
        send_item(ACT_LOAD, "^", 1'b0);
        send_item(ACT_LOAD, "-", 1'b0);
        send_item(ACT_LOAD, "c", 1'b0);
        play_ticks(12);
        send_item(ACT_STOP, 8'hAA, 1'b1);
        send_item(ACT_US, 8'h55, 1'b0);
        send_item(ACT_MS, 8'h00, 1'b0);
        wait_drained();
    endtask

    task automatic test_store_full();
        // overfill the store, then play ticks on the full song and stop
        send_item(ACT_LOAD, "3", 1'b1);
        for (int i = 0; i < Depth + 4; i++) send_item(ACT_LOAD, song_symbol(), 1'b0);
        play_ticks(300);
        send_item(ACT_STOP, 8'h00, 1'b0);
    endtask

    task automatic test_random_songs();
        int n;
        for (int s = 0; s < 28; s++) begin
            n = $urandom_range(1, 12);
            send_item(ACT_LOAD, "3", 1'b1);
            for (int i = 0; i < n; i++) send_item(ACT_LOAD, song_symbol(), 1'b0);
            play_ticks($urandom_range(10, 30));
            if ($urandom_range(0, 3) == 0)
                send_item(ACT_STOP, 8'($urandom), 1'($urandom));
            if ($urandom_range(0, 4) == 0)
                send_item(2'($urandom), 8'($urandom), 1'($urandom));
        end
    endtask

    task automatic test_backpressure();
        // receiver holds off while items keep coming, then a full drain pause
        hold_receiver = 1'b1;
        load_song("3cdefg");
        play_ticks(20);
        wait_drained();
        play_ticks(20);
    endtask

    // Receiver stall: random, with a long counted hold when asked
    initial
    begin
        out_stall = 1'b1;
        rx_random = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_receiver)
            begin
                out_stall <= 1'b1;
                repeat (HoldCycles) @(posedge clk);
                hold_receiver = 1'b0;
            end
            else if (rx_random) out_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    // Check every result transfer against the oldest prediction
    always @(posedge clk)
    begin
        mss_out_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", out_data);
            end else begin
                want = pending_results.pop_front();
                if (want !== out_data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected pin %b tone %b play %b per %0d, got %b %b %b %0d",
                            want.pin_level, want.tone_on, want.playing, want.tone_period_us,
                            out_data.pin_level, out_data.tone_on, out_data.playing,
                            out_data.tone_period_us);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WatchdogLimit) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        mismatches = 0;
        idle_cycles = 0;
        hold_receiver = 1'b0;
        song_len = 0; play_pos = 0; note_left_ms = 0; gap_left_ms = 0;
        beat_ms = 200; legato_off = 1; swing_on = 0; swing_long = 0; transpose = 0;
        silence();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_store_full();
        test_random_songs();
        test_backpressure();
        wait_drained();
        repeat (3 * Depth + 20) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

@@ melody_string_sequencer_core.f @@
src/mss_pkg.sv
src/mss_ram.sv
src/mss_ctrl.sv
src/mss_dp.sv
src/melody_string_sequencer_core.sv
tb/melody_string_sequencer_core_tb.sv
